// ----- design/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants for the LED pattern sequencer
// Holds the pattern codes, the configuration register indexes and reset
// values, and the configuration struct handed to the pattern engine.
// ----------------------------------------------------------------------------
package lps_pkg;

	// Fixed geometry of the LED row.
	localparam int LED_COUNT      = 8;
	localparam int SCAN_PERIOD    = 2 * LED_COUNT - 2;
	localparam int PHASE_BITS     = $clog2(SCAN_PERIOD);
	localparam int STEP_BITS_DEF  = 16;
	localparam int DEBOUNCE_BITS  = 9;
	localparam int INTERVAL_BITS  = 16;
	localparam int DEBOUNCE_CFG_BITS = 8;
	localparam int MODE_BITS      = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// Pattern codes.
	localparam logic [MODE_BITS-1:0] MODE_COUNT     = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_LEFT      = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_RIGHT     = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_ALTERNATE = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_RANDOM    = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_SCANNER   = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ALTERNATE = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANDOM    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCANNER   = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [DEBOUNCE_CFG_BITS-1:0] DEBOUNCE_RST  = 8'd50;
	localparam logic [INTERVAL_BITS-1:0]     COUNT_RST     = 16'd100;
	localparam logic [INTERVAL_BITS-1:0]     SHIFT_RST     = 16'd150;
	localparam logic [INTERVAL_BITS-1:0]     ALTERNATE_RST = 16'd300;
	localparam logic [INTERVAL_BITS-1:0]     RANDOM_RST    = 16'd80;
	localparam logic [INTERVAL_BITS-1:0]     SCANNER_RST   = 16'd100;

	// LED constants.
	localparam logic [LED_COUNT-1:0] LED_EVEN  = 8'h55;
	localparam logic [LED_COUNT-1:0] LED_ODD   = 8'hAA;
	localparam logic [LED_COUNT-1:0] LED_FIRST = 8'h01;
	localparam logic [LED_COUNT-1:0] LED_LAST  = 8'h80;

	// Update periods of the patterns.
	typedef struct packed {
		logic [INTERVAL_BITS-1:0] count;
		logic [INTERVAL_BITS-1:0] shift;
		logic [INTERVAL_BITS-1:0] alternate;
		logic [INTERVAL_BITS-1:0] random;
		logic [INTERVAL_BITS-1:0] scanner;
	} lps_intervals_t;

endpackage

// ----- design/lps_debounce.sv -----
// ----------------------------------------------------------------------------
// lps_debounce: button debouncer
// Counts ticks since the last raw level change and flags a press when a low
// level has been held longer than the debounce setting.
// ----------------------------------------------------------------------------
module lps_debounce
	import lps_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick_en,
	input  logic                         level,
	input  logic [DEBOUNCE_CFG_BITS-1:0] debounce_ms,
	output logic                         press
);

	localparam logic [DEBOUNCE_BITS-1:0] COUNT_MAX = '1;

	logic [DEBOUNCE_BITS-1:0] count_q;
	logic                     raw_last_q;
	logic                     stable_q;
	logic [DEBOUNCE_BITS-1:0] count_next;
	logic                     accept;

	// Restart on a change, otherwise count up and saturate.
	always_comb begin
		if (level != raw_last_q) begin
			count_next = '0;
		end else if (count_q != COUNT_MAX) begin
			count_next = count_q + 1'b1;
		end else begin
			count_next = count_q;
		end
	end

	// A new level held long enough becomes the accepted level.
	assign accept = (count_next > {1'b0, debounce_ms}) && (level != stable_q);
	assign press  = accept && !level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			raw_last_q <= 1'b1;
			stable_q   <= 1'b1;
		end else if (tick_en) begin
			count_q    <= count_next;
			raw_last_q <= level;
			if (accept) begin
				stable_q <= level;
			end
		end
	end

endmodule

// ----- design/lps_pattern.sv -----
// ----------------------------------------------------------------------------
// lps_pattern: pattern engine
// Holds the pattern, step counter, LED byte and update timer, and computes
// the next LED byte for one tick.
// ----------------------------------------------------------------------------
module lps_pattern
	import lps_pkg::*;
#(
	parameter int STEP_BITS = STEP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_en,
	input  logic                 press,
	input  logic [7:0]           random_value,
	input  lps_intervals_t       intervals,
	output logic [LED_COUNT-1:0] led_next,
	output logic [MODE_BITS-1:0] mode_next
);

	localparam logic [STEP_BITS-1:0]     STEP_MAX    = '1;
	localparam logic [INTERVAL_BITS-1:0] ELAPSED_MAX = '1;
	localparam logic [PHASE_BITS-1:0]    PHASE_LAST  = PHASE_BITS'(SCAN_PERIOD - 1);
	localparam logic [PHASE_BITS-1:0]    PHASE_TURN  = PHASE_BITS'(LED_COUNT);
	localparam logic [PHASE_BITS-1:0]    PHASE_SPAN  = PHASE_BITS'(SCAN_PERIOD);

	logic [MODE_BITS-1:0]     mode_q;
	logic [STEP_BITS-1:0]     step_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic [LED_COUNT-1:0]     led_q;
	logic [7:0]               latch_q;
	logic [INTERVAL_BITS-1:0] elapsed_q;

	logic [STEP_BITS-1:0]     step_cur;
	logic [PHASE_BITS-1:0]    phase_cur;
	logic [LED_COUNT-1:0]     led_cur;
	logic [INTERVAL_BITS-1:0] elapsed_inc;
	logic [INTERVAL_BITS-1:0] interval;
	logic                     update;
	logic [7:0]               latch_next;
	logic [LED_COUNT-1:0]     led_pat;
	logic [PHASE_BITS-1:0]    scan_pos;
	logic [2:0]               sub_step;

	// A press moves to the next pattern and restarts it.
	always_comb begin
		mode_next = mode_q;
		step_cur  = step_q;
		phase_cur = phase_q;
		led_cur   = led_q;
		if (press) begin
			mode_next = (mode_q >= MODE_SCANNER) ? MODE_COUNT : mode_q + 1'b1;
			step_cur  = '0;
			phase_cur = '0;
			led_cur   = '0;
		end
	end

	// Update period of the active pattern.
	always_comb begin
		case (mode_next)
			MODE_COUNT:     interval = intervals.count;
			MODE_LEFT:      interval = intervals.shift;
			MODE_RIGHT:     interval = intervals.shift;
			MODE_ALTERNATE: interval = intervals.alternate;
			MODE_RANDOM:    interval = intervals.random;
			MODE_SCANNER:   interval = intervals.scanner;
			default:        interval = intervals.count;
		endcase
	end

	assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign update      = elapsed_inc >= interval;
	assign sub_step    = step_cur[2:0];
	assign scan_pos    = (phase_cur >= PHASE_TURN) ? PHASE_SPAN - phase_cur : phase_cur;
	assign latch_next  = (mode_next == MODE_RANDOM && update && sub_step == 3'd0) ?
		random_value : latch_q;

	// New LED byte for each pattern.
	always_comb begin
		case (mode_next)
			MODE_COUNT:     led_pat = step_cur[7:0];
			MODE_LEFT:      led_pat = (sub_step == 3'd0) ? LED_FIRST :
				{led_cur[LED_COUNT-2:0], led_cur[LED_COUNT-1]};
			MODE_RIGHT:     led_pat = (sub_step == 3'd0) ? LED_LAST :
				{led_cur[0], led_cur[LED_COUNT-1:1]};
			MODE_ALTERNATE: led_pat = step_cur[0] ? LED_ODD : LED_EVEN;
			MODE_RANDOM:    led_pat = latch_next & ((8'd1 << sub_step) - 8'd1);
			MODE_SCANNER:   led_pat = LED_FIRST << scan_pos[2:0];
			default:        led_pat = led_cur;
		endcase
	end

	assign led_next = update ? led_pat : led_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_COUNT;
			step_q    <= '0;
			phase_q   <= '0;
			led_q     <= '0;
			latch_q   <= '0;
			elapsed_q <= '0;
		end else if (tick_en) begin
			mode_q  <= mode_next;
			led_q   <= led_next;
			latch_q <= latch_next;
			if (update) begin
				elapsed_q <= '0;
				step_q    <= step_cur + 1'b1;
				// Scanner phase tracks the step modulo the scan period.
				if (step_cur == STEP_MAX || phase_cur == PHASE_LAST) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_cur + 1'b1;
				end
			end else begin
				elapsed_q <= elapsed_inc;
				step_q    <= step_cur;
				phase_q   <= phase_cur;
			end
		end
	end

endmodule

// ----- design/led_pattern_sequencer.sv -----
// ----------------------------------------------------------------------------
// led_pattern_sequencer: eight-LED pattern generator with debounced button
// Each input word is one millisecond tick with the raw button level and a
// random byte; each tick yields one output word with the LED byte and the
// current pattern.
//
// Usage:
//   Input channel in_valid/in_stall carries button_level and random_value.
//   Output channel out_valid/out_stall carries led_bits and pattern_index.
//   A word is accepted at a clock edge where valid is high and stall is low.
//   One word is accepted per cycle when the output is not stalled.
//   The tick is processed in one pass from the input register into the
//   output register; all debounce and pattern state updates in that cycle.
//   When the receiver stalls, the output word holds and the input register
//   fills, after which in_stall rises; no word is lost or repeated.
//   Reset clears the debounce and pattern state, restores the configuration
//   defaults and empties both registers. Configuration is written through
//   cfg_we, cfg_index and cfg_data while the block is idle.
// ----------------------------------------------------------------------------
module led_pattern_sequencer
	import lps_pkg::*;
#(
	parameter int STEP_BITS = STEP_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      button_level,
	input  logic [7:0]                random_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [LED_COUNT-1:0]      led_bits,
	output logic [MODE_BITS-1:0]      pattern_index,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	logic [DEBOUNCE_CFG_BITS-1:0] debounce_ms_q;
	lps_intervals_t               intervals_q;

	logic                 valid_s1;
	logic                 button_s1;
	logic [7:0]           random_s1;
	logic                 out_valid_q;
	logic [LED_COUNT-1:0] led_q;
	logic [MODE_BITS-1:0] mode_q;

	logic                 advance;
	logic                 press;
	logic [LED_COUNT-1:0] led_next;
	logic [MODE_BITS-1:0] mode_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q         <= DEBOUNCE_RST;
			intervals_q.count     <= COUNT_RST;
			intervals_q.shift     <= SHIFT_RST;
			intervals_q.alternate <= ALTERNATE_RST;
			intervals_q.random    <= RANDOM_RST;
			intervals_q.scanner   <= SCANNER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:  debounce_ms_q         <= cfg_data[DEBOUNCE_CFG_BITS-1:0];
				REG_COUNT:     intervals_q.count     <= cfg_data;
				REG_SHIFT:     intervals_q.shift     <= cfg_data;
				REG_ALTERNATE: intervals_q.alternate <= cfg_data;
				REG_RANDOM:    intervals_q.random    <= cfg_data;
				REG_SCANNER:   intervals_q.scanner   <= cfg_data;
				default:       ;
			endcase
		end
	end

	// The tick in the input register moves on when the output can take it.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			button_s1 <= button_level;
			random_s1 <= random_value;
		end
	end

	lps_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_en     (advance),
		.level       (button_s1),
		.debounce_ms (debounce_ms_q),
		.press       (press)
	);

	lps_pattern #(
		.STEP_BITS (STEP_BITS)
	) u_pattern (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_en      (advance),
		.press        (press),
		.random_value (random_s1),
		.intervals    (intervals_q),
		.led_next     (led_next),
		.mode_next    (mode_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_q  <= led_next;
			mode_q <= mode_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign led_bits      = led_q;
	assign pattern_index = mode_q;

endmodule

// ----- tb/led_pattern_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// led_pattern_sequencer_tb: self-checking bench for the LED pattern sequencer
// Sends millisecond tick words with button and random bytes through the
// valid/stall input, keeps a cycle-free model of the debounce and pattern
// state, and compares every LED word that leaves the block against it.
// Both sides insert random gaps, and the receiver holds off long enough once
// to back the block up. Configuration changes only while nothing is in flight.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_tb;
	import lps_pkg::*;

	localparam int MAX_GAP = 14;

	typedef struct packed {
		logic [LED_COUNT-1:0] led;
		logic [MODE_BITS-1:0] mode;
	} led_word_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      button_level;
	logic [7:0]                random_value;
	logic                      out_valid;
	logic                      out_stall;
	logic [LED_COUNT-1:0]      led_bits;
	logic [MODE_BITS-1:0]      pattern_index;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// Bench control shared between the stimulus and the receiver.
	bit sender_gaps      = 1'b1;
	bit receiver_gaps    = 1'b1;
	int long_hold_cycles = 0;
	int ticks_sent       = 0;
	int mismatches       = 0;

	led_word_t led_expected[$];

	// Model copy of the configuration.
	logic [DEBOUNCE_CFG_BITS-1:0] cf_debounce;
	lps_intervals_t               cf_intervals;

	// Model copy of the block state.
	logic [DEBOUNCE_BITS-1:0] ms_debounce;
	logic                     ms_raw;
	logic                     ms_stable;
	logic [MODE_BITS-1:0]     ms_mode;
	logic [STEP_BITS_DEF-1:0] ms_step;
	logic [LED_COUNT-1:0]     ms_led;
	logic [7:0]               ms_latch;
	logic [INTERVAL_BITS-1:0] ms_elapsed;

	led_pattern_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.led_bits     (led_bits),
		.pattern_index(pattern_index),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Puts the model into its post-reset state.
	function automatic void reset_model();
		cf_debounce            = DEBOUNCE_RST;
		cf_intervals.count     = COUNT_RST;
		cf_intervals.shift     = SHIFT_RST;
		cf_intervals.alternate = ALTERNATE_RST;
		cf_intervals.random    = RANDOM_RST;
		cf_intervals.scanner   = SCANNER_RST;
		ms_debounce = '0;
		ms_raw      = 1'b1;
		ms_stable   = 1'b1;
		ms_mode     = MODE_COUNT;
		ms_step     = '0;
		ms_led      = '0;
		ms_latch    = '0;
		ms_elapsed  = '0;
	endfunction

	// Advances the model by one tick and queues the LED word it produces.
	function automatic void predict_tick(input logic level, input logic [7:0] rnd);
		logic [INTERVAL_BITS-1:0] period;
		int phase;

		// Debounce: a raw change restarts the count, a long enough hold is accepted.
		if (level != ms_raw)
			ms_debounce = '0;
		else if (ms_debounce != '1)
			ms_debounce = ms_debounce + 1'b1;
		if (ms_debounce > cf_debounce && level != ms_stable) begin
			ms_stable = level;
			if (!level) begin
				ms_mode = (ms_mode == MODE_SCANNER) ? MODE_COUNT : ms_mode + 1'b1;
				ms_step = '0;
				ms_led  = '0;
			end
		end
		ms_raw = level;

		// The elapsed count is bumped before the compare, and is kept across a mode change.
		if (ms_elapsed != '1)
			ms_elapsed = ms_elapsed + 1'b1;
		case (ms_mode)
			MODE_LEFT, MODE_RIGHT: period = cf_intervals.shift;
			MODE_ALTERNATE:        period = cf_intervals.alternate;
			MODE_RANDOM:           period = cf_intervals.random;
			MODE_SCANNER:          period = cf_intervals.scanner;
			default:               period = cf_intervals.count;
		endcase

		if (ms_elapsed >= period) begin
			ms_elapsed = '0;
			case (ms_mode)
				MODE_COUNT: begin
					ms_led = ms_step[LED_COUNT-1:0];
				end
				MODE_LEFT: begin
					ms_led = (ms_step % LED_COUNT == 0) ? LED_FIRST :
						{ms_led[LED_COUNT-2:0], ms_led[LED_COUNT-1]};
				end
				MODE_RIGHT: begin
					ms_led = (ms_step % LED_COUNT == 0) ? LED_LAST :
						{ms_led[0], ms_led[LED_COUNT-1:1]};
				end
				MODE_ALTERNATE: begin
					ms_led = ms_step[0] ? LED_ODD : LED_EVEN;
				end
				MODE_RANDOM: begin
					if (ms_step[2:0] == 3'd0)
						ms_latch = rnd;
					ms_led = ms_latch & ((LED_FIRST << ms_step[2:0]) - LED_FIRST);
				end
				MODE_SCANNER: begin
					phase = ms_step % SCAN_PERIOD;
					if (phase >= LED_COUNT)
						phase = SCAN_PERIOD - phase;
					ms_led = LED_FIRST << phase;
				end
				default: begin
				end
			endcase
			ms_step = ms_step + 1'b1;
		end
		led_expected.push_back('{led: ms_led, mode: ms_mode});
	endfunction

	// Offers one tick word after a random gap and holds it until accepted.
	task automatic send_tick(input logic level, input logic [7:0] rnd);
		int gap;

		gap = sender_gaps ? $urandom_range(MAX_GAP, 0) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		button_level <= level;
		random_value <= rnd;
		do @(posedge clk); while (in_stall);
		predict_tick(level, rnd);
		ticks_sent++;
	endtask

	task automatic send_ticks(input logic level, input int count);
		repeat (count) send_tick(level, 8'($urandom_range(255, 0)));
	endtask

	// Drops valid and waits until every queued LED word has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (led_expected.size() != 0) @(posedge clk);
	endtask

	// Writes every register index once, the spare indexes with noise.
	task automatic apply_config(input logic [DEBOUNCE_CFG_BITS-1:0] deb,
			input lps_intervals_t itv);
		logic [CFG_DATA_BITS-1:0] reg_words [1 << CFG_INDEX_BITS];
		int i;

		drain_results();
		foreach (reg_words[k])
			reg_words[k] = CFG_DATA_BITS'($urandom_range(16'hFFFF, 0));
		reg_words[REG_DEBOUNCE]  = {8'($urandom_range(255, 0)), deb};
		reg_words[REG_COUNT]     = itv.count;
		reg_words[REG_SHIFT]     = itv.shift;
		reg_words[REG_ALTERNATE] = itv.alternate;
		reg_words[REG_RANDOM]    = itv.random;
		reg_words[REG_SCANNER]   = itv.scanner;
		for (i = 0; i < (1 << CFG_INDEX_BITS); i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_INDEX_BITS-1:0];
			cfg_data  <= reg_words[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cf_debounce  = deb;
		cf_intervals = itv;
	endtask

	function automatic logic [INTERVAL_BITS-1:0] pick_interval();
		int r;

		r = $urandom_range(11, 0);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return INTERVAL_BITS'($urandom_range(6, 1));
	endfunction

	// Mostly clean presses and releases held just past the debounce time, some bounce.
	task automatic run_button_traffic(input int count);
		int start;

		start = ticks_sent;
		while (ticks_sent - start < count) begin
			if ($urandom_range(9, 0) < 8) begin
				send_ticks(1'b1, cf_debounce + $urandom_range(6, 1));
				send_ticks(1'b0, cf_debounce + $urandom_range(5, 1));
			end else begin
				repeat ($urandom_range(5, 1))
					send_tick(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
			end
		end
	endtask

	// With the reset configuration nothing updates yet; LEDs stay dark in count mode.
	task automatic test_reset_defaults();
		send_tick(1'b1, 8'hFF);
		send_tick(1'b1, 8'h00);
		send_tick(1'b1, 8'hA5);
	endtask

	// Walks through all six patterns with one-tick debounce, updating every tick.
	// A zero interval updates on every tick, and a press lands on an update tick.
	task automatic test_pattern_walk();
		lps_intervals_t itv;

		itv = '{count: 16'd1, shift: 16'd1, alternate: 16'd0, random: 16'd1, scanner: 16'd0};
		apply_config('0, itv);
		send_tick(1'b1, 8'hFF);
		repeat (6) begin
			send_tick(1'b0, 8'hFF);
			send_tick(1'b0, 8'h00);
			send_tick(1'b1, 8'hFF);
			send_tick(1'b1, 8'h00);
		end
	endtask

	// Longest debounce and longest intervals: one press gets through, nothing updates.
	task automatic test_slow_extremes();
		lps_intervals_t itv;

		itv = '{count: '1, shift: '1, alternate: '1, random: '1, scanner: '1};
		apply_config('1, itv);
		send_ticks(1'b0, 258);
	endtask

	// Several random settings, some phases with no gaps on either side.
	task automatic test_random_configs();
		lps_intervals_t itv;
		logic [DEBOUNCE_CFG_BITS-1:0] deb;

		for (int ph = 0; ph < 6; ph++) begin
			deb = (ph == 0) ? '0 : DEBOUNCE_CFG_BITS'($urandom_range(6, 0));
			itv.count     = pick_interval();
			itv.shift     = pick_interval();
			itv.alternate = pick_interval();
			itv.random    = pick_interval();
			itv.scanner   = pick_interval();
			apply_config(deb, itv);
			sender_gaps   = ($urandom_range(3, 0) != 0);
			receiver_gaps = ($urandom_range(3, 0) != 0);
			run_button_traffic(60);
		end
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	// The receiver holds off for a long stretch while words keep coming back to back.
	task automatic test_output_backpressure();
		lps_intervals_t itv;

		itv = '{count: 16'd1, shift: 16'd2, alternate: 16'd1, random: 16'd3, scanner: 16'd1};
		apply_config(8'd2, itv);
		sender_gaps      = 1'b0;
		long_hold_cycles = 48;
		run_button_traffic(60);
		sender_gaps = 1'b1;
	endtask

	// Runs the scanner back to back through several bounce periods.
	task automatic test_scanner_run();
		lps_intervals_t itv;

		itv = '{count: 16'd1, shift: 16'd1, alternate: 16'd1, random: 16'd1, scanner: 16'd1};
		apply_config('0, itv);
		while (ms_mode != MODE_SCANNER) begin
			send_ticks(1'b1, 2);
			send_ticks(1'b0, 2);
		end
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		send_ticks(1'b1, 80);
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	// Receiver: random stall before each word, or one long hold when asked.
	initial begin : receiver
		int n;

		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = receiver_gaps ? $urandom_range(MAX_GAP, 0) : 0;
			if (long_hold_cycles > 0) begin
				n = long_hold_cycles;
				long_hold_cycles = 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Compare each accepted LED word with the oldest prediction.
	always @(posedge clk) begin
		led_word_t want;

		if (arst_n && out_valid && !out_stall) begin
			if (led_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: led_bits %02h pattern_index %0d",
						led_bits, pattern_index);
			end else begin
				want = led_expected.pop_front();
				if (led_bits !== want.led || pattern_index !== want.mode) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: led_bits exp %02h got %02h, ",
							"pattern_index exp %0d got %0d"},
							want.led, led_bits, want.mode, pattern_index);
				end
			end
		end
	end

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		button_level <= 1'b1;
		random_value <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_DEBOUNCE;
		cfg_data     <= '0;
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_pattern_walk();
		test_slow_extremes();
		test_random_configs();
		test_output_backpressure();
		test_scanner_run();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- led_pattern_sequencer.f -----
design/lps_pkg.sv
design/lps_debounce.sv
design/lps_pattern.sv
design/led_pattern_sequencer.sv
tb/led_pattern_sequencer_tb.sv
